// ===== rtl/core/dfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dfs_pkg;
  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned MaxEdges    = 4096;
  localparam int unsigned VW = $clog2(MaxVertices);
  localparam int unsigned EW = $clog2(MaxEdges);
  localparam int unsigned CW = 11;
  localparam int unsigned DW = 13;

  localparam logic [1:0] REQ_ROW   = 2'd0;
  localparam logic [1:0] REQ_EDGE  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  typedef logic [VW-1:0] vtx_t;
  typedef logic [EW-1:0] slot_t;

  // parent word as kept in the mark memory
  typedef struct packed {
    logic seen;
    vtx_t par;
  } mark_t;
endpackage
`default_nettype wire

// ===== rtl/core/dfs_mark_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// parent marks, one word per vertex; cleared by the owner with a pass of writes
module dfs_mark_ram (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire dfs_pkg::vtx_t  waddr,
  input  wire dfs_pkg::mark_t wdata,
  input  wire dfs_pkg::vtx_t  raddr,
  output dfs_pkg::mark_t      rdata
);
  dfs_pkg::mark_t mem [dfs_pkg::MaxVertices];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/csr_depth_first_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   | strobe        | fields
// ----------+---------------+-------------------------------------------------
// request   | start & !busy | req_type vertex edge_start degree edge_slot edge_dest
// result    | done          | visited parent processed_count source_error
// config    | cfg_we        | cfg_data (vertex_count)
// loads give no word; a query gives its word from S_QRY once the mark read is
// registered, a start with a bad source in the next cycle.
// a search clears the 1024 marks, seeds, then per popped vertex steps QWAIT, POP, ROW,
// EDGE, per edge slot MARK, EV, EDGE, and ends by QWAIT, POP; busy holds off new words.
// reset runs the same clearing pass over all 1024 marks with busy high.
// the receiver cannot stall: done lasts one cycle.
module csr_depth_first_search (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [9:0]  vertex,
  input  wire logic [11:0] edge_start,
  input  wire logic [12:0] degree,
  input  wire logic [11:0] edge_slot,
  input  wire logic [9:0]  edge_dest,
  output logic             done,
  output logic             visited,
  output logic [9:0]       parent,
  output logic [10:0]      processed_count,
  output logic             source_error
);
  localparam logic [3:0] S_IDLE = 4'd0, S_QRY = 4'd1, S_POP = 4'd2, S_ROW = 4'd3,
                         S_EDGE = 4'd4, S_MARK = 4'd5, S_EV = 4'd6, S_QWAIT = 4'd7,
                         S_CLR = 4'd8, S_SEED = 4'd9;

  logic [3:0] state;
  logic [10:0] vcount;
  logic accept;
  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  logic [dfs_pkg::EW-1:0] rstart_mem [dfs_pkg::MaxVertices];
  logic [dfs_pkg::DW-1:0] rdeg_mem [dfs_pkg::MaxVertices];
  dfs_pkg::vtx_t edge_mem [dfs_pkg::MaxEdges];
  dfs_pkg::vtx_t stack_mem [dfs_pkg::MaxVertices];

  dfs_pkg::vtx_t cur, u, row_addr, st_q;
  logic [dfs_pkg::EW-1:0] rs_q;
  logic [dfs_pkg::DW-1:0] rd_q;
  logic [dfs_pkg::DW:0] slot_ptr;
  logic [dfs_pkg::DW-1:0] left;
  dfs_pkg::slot_t edge_addr;
  logic [10:0] sp, processed;
  logic push;

  logic mwe;
  dfs_pkg::vtx_t mwaddr, mraddr, src, clr_addr;
  dfs_pkg::mark_t mwdata, mq;
  logic clr_search;

  dfs_mark_ram u_marks (
    .clk(clk), .we(mwe), .waddr(mwaddr), .wdata(mwdata),
    .raddr(mraddr), .rdata(mq)
  );

  logic src_ok;
  assign src_ok = {1'b0, vertex} < vcount;
  logic u_ok;
  assign u_ok = {1'b0, u} < vcount;

  assign push = (state == S_EV) && u_ok && !mq.seen;
  assign mwe = (state == S_CLR) || (state == S_SEED) || push;
  assign mwaddr = (state == S_CLR) ? clr_addr : ((state == S_SEED) ? src : u);
  assign mraddr = (state == S_IDLE) ? vertex : u;

  // clearing pass writes unvisited words, the seed marks the source as its own parent
  always_comb begin
    mwdata.seen = (state != S_CLR);
    mwdata.par = (state == S_CLR) ? '0 : ((state == S_SEED) ? src : cur);
  end

  always_ff @(posedge clk) begin
    if (accept && req_type == dfs_pkg::REQ_ROW) begin
      rstart_mem[vertex] <= edge_start;
      rdeg_mem[vertex] <= degree;
    end
    rs_q <= rstart_mem[row_addr];
    rd_q <= rdeg_mem[row_addr];
    if (accept && req_type == dfs_pkg::REQ_EDGE) edge_mem[edge_slot] <= edge_dest;
    u <= edge_mem[edge_addr];
    if (state == S_SEED) stack_mem[0] <= src;
    else if (push) stack_mem[sp[dfs_pkg::VW-1:0]] <= u;
    st_q <= stack_mem[sp[dfs_pkg::VW-1:0] - 1'b1];
  end
  assign row_addr = st_q;
  assign edge_addr = slot_ptr[dfs_pkg::EW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      clr_search <= 1'b0;
      vcount <= 11'd1024;
      done <= 1'b0;
      sp <= '0;
      processed <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) vcount <= (cfg_data > 11'd1024) ? 11'd1024 : cfg_data;
      unique case (state)
        S_IDLE: if (accept) begin
          unique case (req_type)
            dfs_pkg::REQ_ROW, dfs_pkg::REQ_EDGE: ;
            dfs_pkg::REQ_QUERY: state <= S_QRY;
            dfs_pkg::REQ_START: begin
              if (src_ok) begin
                src <= vertex;
                clr_addr <= '0;
                clr_search <= 1'b1;
                state <= S_CLR;
              end else begin
                done <= 1'b1;
                visited <= 1'b0;
                parent <= '0;
                processed_count <= '0;
                source_error <= 1'b1;
              end
            end
          endcase
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= clr_search ? S_SEED : S_IDLE;
        end
        S_SEED: begin
          sp <= 11'd1;
          processed <= '0;
          state <= S_QWAIT;
        end
        S_QRY: begin
          done <= 1'b1;
          visited <= mq.seen;
          parent <= mq.seen ? mq.par : '0;
          processed_count <= '0;
          source_error <= 1'b0;
          state <= S_IDLE;
        end
        S_QWAIT: state <= S_POP; // stack read of top settles
        S_POP: begin
          if (sp == '0) begin
            done <= 1'b1;
            visited <= 1'b0;
            parent <= '0;
            processed_count <= processed;
            source_error <= 1'b0;
            state <= S_IDLE;
          end else begin
            cur <= st_q;
            sp <= sp - 1'b1;
            processed <= processed + 1'b1;
            state <= S_ROW;
          end
        end
        S_ROW: begin
          slot_ptr <= {2'b0, rs_q};
          left <= rd_q;
          state <= S_EDGE;
        end
        S_EDGE: begin
          if (left == '0 || slot_ptr >= (dfs_pkg::DW+1)'(dfs_pkg::MaxEdges)) state <= S_QWAIT;
          else state <= S_MARK;
        end
        S_MARK: state <= S_EV; // edge word in u, mark read issued
        S_EV: begin
          if (push) sp <= sp + 1'b1;
          slot_ptr <= slot_ptr + 1'b1;
          left <= left - 1'b1;
          state <= S_EDGE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    done && source_error |-> !visited && processed_count == '0)
    else $error("error word carries data");
  a_sp_bound: assert property (@(posedge clk) disable iff (rst) sp <= 11'd1024)
    else $error("stack overflow");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("word while busy");
endmodule
`default_nettype wire

// ===== test/csr_depth_first_search_tb.sv =====
`timescale 1ns / 1ps
module csr_depth_first_search_tb;

  localparam int CycleLimit = 4000000;

  typedef struct packed {
    logic        visited;
    logic [9:0]  parent;
    logic [10:0] processed_count;
    logic        source_error;
  } dfs_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = dfs_pkg::REQ_ROW;
  logic [9:0]  vertex = '0;
  logic [11:0] edge_start = '0;
  logic [12:0] degree = '0;
  logic [11:0] edge_slot = '0;
  logic [9:0]  edge_dest = '0;
  logic        done;
  logic        visited;
  logic [9:0]  parent;
  logic [10:0] processed_count;
  logic        source_error;

  csr_depth_first_search i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .req_type(req_type), .vertex(vertex),
    .edge_start(edge_start), .degree(degree), .edge_slot(edge_slot),
    .edge_dest(edge_dest), .done(done), .visited(visited), .parent(parent),
    .processed_count(processed_count), .source_error(source_error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the graph and of the search marks
  logic [11:0] g_row_start [dfs_pkg::MaxVertices];
  logic [12:0] g_row_degree[dfs_pkg::MaxVertices];
  logic [9:0]  g_edge_dest [dfs_pkg::MaxEdges];
  bit          g_row_loaded[dfs_pkg::MaxVertices];
  bit          g_edge_loaded[dfs_pkg::MaxEdges];
  bit          g_seen      [dfs_pkg::MaxVertices];
  logic [9:0]  g_parent    [dfs_pkg::MaxVertices];
  int          g_count = 1024;

  dfs_word_t   pending_words[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  int          items_sent = 0;

  function automatic int count_limit();
    return g_count > dfs_pkg::MaxVertices ? dfs_pkg::MaxVertices : g_count;
  endfunction

  // walks the shadow graph; flags any read of a never-loaded entry
  function automatic int dfs_walk(input int src, input int lim, input bit commit,
                                  output bit touches_unloaded);
    bit         seen[dfs_pkg::MaxVertices];
    logic [9:0] par [dfs_pkg::MaxVertices];
    int         stk [dfs_pkg::MaxVertices];
    int         sp, cnt, v, base, dg, s, u;
    touches_unloaded = 0;
    for (int i = 0; i < dfs_pkg::MaxVertices; i++) begin
      seen[i] = 0;
      par[i] = '0;
    end
    sp = 0;
    cnt = 0;
    stk[sp++] = src;
    seen[src] = 1;
    par[src] = src[9:0];
    while (sp > 0) begin
      v = stk[--sp];
      cnt++;
      if (!g_row_loaded[v]) touches_unloaded = 1;
      base = g_row_start[v];
      dg = g_row_degree[v];
      for (int k = 0; k < dg; k++) begin
        s = base + k;
        if (s >= dfs_pkg::MaxEdges) break;
        if (!g_edge_loaded[s]) touches_unloaded = 1;
        u = g_edge_dest[s];
        if (u >= lim) continue;
        if (!seen[u]) begin
          seen[u] = 1;
          par[u] = v[9:0];
          if (sp < dfs_pkg::MaxVertices) stk[sp++] = u;
        end
      end
    end
    if (commit) begin
      g_seen = seen;
      g_parent = par;
    end
    return cnt;
  endfunction

  function automatic bit start_is_safe(input int src);
    bit bad;
    if (src >= count_limit()) return 1;
    void'(dfs_walk(src, count_limit(), 0, bad));
    return !bad;
  endfunction

  function automatic void predict_word(input logic [1:0] rq, input logic [9:0] v,
                                       input logic [11:0] es, input logic [12:0] dg,
                                       input logic [11:0] sl, input logic [9:0] de);
    dfs_word_t w;
    bit bad;
    w = '0;
    case (rq)
      dfs_pkg::REQ_ROW: begin
        g_row_start[v] = es;
        g_row_degree[v] = dg;
        g_row_loaded[v] = 1;
      end
      dfs_pkg::REQ_EDGE: begin
        g_edge_dest[sl] = de;
        g_edge_loaded[sl] = 1;
      end
      dfs_pkg::REQ_START: begin
        if (v >= count_limit()) w.source_error = 1'b1;
        else w.processed_count = 11'(dfs_walk(v, count_limit(), 1, bad));
        pending_words.push_back(w);
      end
      default: begin
        if (g_seen[v]) begin
          w.visited = 1'b1;
          w.parent = g_parent[v];
        end
        pending_words.push_back(w);
      end
    endcase
  endfunction

  // called and returns at a rising edge; start is left high unless an idle gap is drawn
  task automatic send_word(input logic [1:0] rq, input int v, input int es = 0,
                           input int dg = 0, input int sl = 0, input int de = 0);
    req_type <= rq;
    vertex <= v[9:0];
    edge_start <= es[11:0];
    degree <= dg[12:0];
    edge_slot <= sl[11:0];
    edge_dest <= de[9:0];
    start <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_word(rq, v[9:0], es[11:0], dg[12:0], sl[11:0], de[9:0]);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_start(input int v);
    if (start_is_safe(v)) send_word(dfs_pkg::REQ_START, v);
    else send_word(dfs_pkg::REQ_QUERY, v);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_vertex_count(input int n);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= n[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    g_count = n;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // done lasts a full cycle, so sample it mid-cycle
  always @(negedge clk) begin
    dfs_word_t got, want;
    if (!rst && done) begin
      got = '{visited, parent, processed_count, source_error};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("word mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic test_directed();
    send_word(dfs_pkg::REQ_QUERY, 0);
    send_word(dfs_pkg::REQ_QUERY, 1023);
    send_word(dfs_pkg::REQ_ROW, 0, 0, 2);
    send_word(dfs_pkg::REQ_ROW, 1023, 4095, 4096);
    send_word(dfs_pkg::REQ_EDGE, 0, 0, 0, 0, 1023);
    send_word(dfs_pkg::REQ_EDGE, 0, 0, 0, 1, 1023);
    send_word(dfs_pkg::REQ_EDGE, 0, 0, 0, 4095, 0);
    send_start(0);
    send_word(dfs_pkg::REQ_QUERY, 1023);
    send_word(dfs_pkg::REQ_QUERY, 0);
    send_start(1023);
    send_word(dfs_pkg::REQ_QUERY, 0);
    set_vertex_count(1);
    send_start(0);
    send_word(dfs_pkg::REQ_QUERY, 1023);
    send_start(5);
    send_word(dfs_pkg::REQ_QUERY, 0);
    set_vertex_count(2047);
    send_start(1023);
    send_word(dfs_pkg::REQ_QUERY, 1023);
    set_vertex_count(1024);
    send_start(1023);
    send_word(dfs_pkg::REQ_QUERY, 1);
  endtask

  task automatic build_and_search();
    int lim, n, base, dg, slot;
    int ids[$];
    lim = count_limit();
    n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    for (int i = 0; i < n; i++) ids.push_back($urandom_range(lim - 1));
    foreach (ids[i]) begin
      if ($urandom_range(15) == 0) begin
        // row running past the last slot
        dg = $urandom_range(3, 4096);
        base = 4095 - $urandom_range(2);
      end else begin
        dg = $urandom_range(4);
        base = $urandom_range(4095 - dg);
      end
      send_word(dfs_pkg::REQ_ROW, ids[i], base, dg);
      for (int k = 0; k < dg && base + k < dfs_pkg::MaxEdges; k++) begin
        slot = base + k;
        send_word(dfs_pkg::REQ_EDGE, 0, 0, 0, slot,
                  $urandom_range(5) == 0 ? $urandom_range(1023)
                                         : ids[$urandom_range(n - 1)]);
      end
    end
    repeat ($urandom_range(2, 4)) begin
      if (idle_pct > 50 && $urandom_range(3) == 0) wait_drained();
      send_start($urandom_range(7) == 0 ? $urandom_range(1023) : ids[$urandom_range(n - 1)]);
      repeat ($urandom_range(2, 6))
        send_word(dfs_pkg::REQ_QUERY, $urandom_range(3) == 0 ? $urandom_range(1023)
                                                            : ids[$urandom_range(n - 1)]);
    end
    // noise
    repeat ($urandom_range(3)) begin
      case ($urandom_range(3))
        0: send_word(dfs_pkg::REQ_ROW, $urandom_range(1023), $urandom_range(4095),
                     $urandom_range(4096));
        1: send_word(dfs_pkg::REQ_EDGE, 0, 0, 0, $urandom_range(4095), $urandom_range(1023));
        2: send_start($urandom_range(1023));
        default: send_word(dfs_pkg::REQ_QUERY, $urandom_range(1023));
      endcase
    end
  endtask

  task automatic test_random_phase(input int pct, input int target);
    int graphs;
    idle_pct = pct;
    graphs = 0;
    while (items_sent < target) begin
      if (graphs % 3 == 0) begin
        case ($urandom_range(4))
          0: set_vertex_count(1);
          1: set_vertex_count(1024);
          2: set_vertex_count($urandom_range(1025, 2047));
          default: set_vertex_count($urandom_range(2, 1023));
        endcase
      end
      build_and_search();
      graphs++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 32;
    test_directed();
    test_random_phase(32, 260);
    test_random_phase(71, 490);
    test_random_phase(0, 720);
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/dfs_pkg.sv
rtl/core/dfs_mark_ram.sv
rtl/core/csr_depth_first_search.sv
test/csr_depth_first_search_tb.sv
